// ----- design/signed_integer_alu_mul_div_assert.svh -----
// Assertion macros shared by the arithmetic unit's modules.
`ifndef SIGNED_INTEGER_ALU_MUL_DIV_ASSERT_SVH
`define SIGNED_INTEGER_ALU_MUL_DIV_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIALU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sialu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sialu: next-cycle check failed");

`endif

// ----- design/sialu_pkg.sv -----
`timescale 1ns / 1ps

package sialu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Steps = WordW;
  localparam int unsigned CntW  = $clog2(Steps);

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [WordW-1:0]        uword_t;
  typedef logic [CntW-1:0]         cnt_t;

  localparam word_t IntMin   = {1'b1, {(WordW-1){1'b0}}};
  localparam word_t MinusOne = '1;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_DIV_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDSUB,
    S_MUL,
    S_ABS_A,
    S_ABS_B,
    S_DIV,
    S_NEG_Q,
    S_NEG_R,
    S_FINISH
  } state_t;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ADDSUB,
    OP_MUL_STEP,
    OP_ABS_A,
    OP_ABS_B,
    OP_DIV_STEP,
    OP_NEG_Q,
    OP_NEG_R,
    OP_CAPTURE
  } dp_op_t;

endpackage

// ----- design/sialu_if.sv -----
`timescale 1ns / 1ps

interface sialu_in_if;
  import sialu_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  word_t operand_a;
  word_t operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

interface sialu_out_if;
  import sialu_pkg::*;

  logic    valid;
  logic    ready;
  word_t   result_value;
  word_t   remainder_value;
  status_t status;

  modport source (output valid, output result_value, output remainder_value,
                  output status, input ready);
  modport sink   (input valid, input result_value, input remainder_value,
                  input status, output ready);
endinterface

// ----- design/sialu_dpath.sv -----
`timescale 1ns / 1ps
`include "signed_integer_alu_mul_div_assert.svh"

module sialu_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  sialu_pkg::dp_op_t op,
  input  sialu_pkg::mode_t  in_mode,
  input  sialu_pkg::word_t  in_a,
  input  sialu_pkg::word_t  in_b,
  output logic              div_err,
  output sialu_pkg::word_t  out_result,
  output sialu_pkg::word_t  out_remainder,
  output sialu_pkg::status_t out_status
);
  import sialu_pkg::*;

  mode_t   mode_r, mode_nxt;
  uword_t  a_r, a_nxt;        // multiplicand, or dividend / quotient shifter
  uword_t  b_r, b_nxt;        // multiplier, or divisor
  uword_t  acc_r, acc_nxt;    // product accumulator, or partial remainder
  logic    q_neg_r, q_neg_nxt;
  logic    r_neg_r, r_neg_nxt;
  status_t status_r, status_nxt;
  word_t   res_out_r, res_out_nxt;
  word_t   rem_out_r, rem_out_nxt;
  status_t sts_out_r, sts_out_nxt;

  // Shared adder / subtractor
  uword_t         alu_x;
  uword_t         alu_y;
  logic           alu_sub;
  logic [WordW:0] alu_sum;
  logic           alu_carry;
  uword_t         shifted;
  logic           err;

  assign shifted   = {acc_r[WordW-2:0], a_r[WordW-1]};
  assign alu_sum   = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                     + {{WordW{1'b0}}, alu_sub};
  assign alu_carry = alu_sum[WordW];
  assign err       = (status_r != STATUS_OK);
  assign div_err   = err;

  always_comb begin
    alu_x   = a_r;
    alu_y   = b_r;
    alu_sub = 1'b0;
    unique case (op)
      OP_ADDSUB: begin
        alu_sub = (mode_r == MODE_SUB);
      end
      OP_MUL_STEP: begin
        alu_x = acc_r;
        alu_y = a_r;
      end
      OP_ABS_A, OP_NEG_Q: begin
        alu_x   = '0;
        alu_y   = a_r;
        alu_sub = 1'b1;
      end
      OP_ABS_B: begin
        alu_x   = '0;
        alu_y   = b_r;
        alu_sub = 1'b1;
      end
      OP_DIV_STEP: begin
        alu_x   = shifted;
        alu_sub = 1'b1;
      end
      OP_NEG_R: begin
        alu_x   = '0;
        alu_y   = acc_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt    = mode_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    acc_nxt     = acc_r;
    q_neg_nxt   = q_neg_r;
    r_neg_nxt   = r_neg_r;
    status_nxt  = status_r;
    res_out_nxt = res_out_r;
    rem_out_nxt = rem_out_r;
    sts_out_nxt = sts_out_r;
    unique case (op)
      OP_LOAD: begin
        mode_nxt  = in_mode;
        a_nxt     = uword_t'(in_a);
        b_nxt     = uword_t'(in_b);
        acc_nxt   = '0;
        q_neg_nxt = in_a[WordW-1] ^ in_b[WordW-1];
        r_neg_nxt = in_a[WordW-1];
        if (in_mode != MODE_DIV) begin
          status_nxt = STATUS_OK;
        end else if (in_b == '0) begin
          status_nxt = STATUS_DIV_ZERO;
        end else if (in_a == IntMin && in_b == MinusOne) begin
          status_nxt = STATUS_DIV_OVF;
        end else begin
          status_nxt = STATUS_OK;
        end
      end
      OP_ADDSUB: begin
        acc_nxt = alu_sum[WordW-1:0];
      end
      OP_MUL_STEP: begin
        if (b_r[0]) begin
          acc_nxt = alu_sum[WordW-1:0];
        end
        a_nxt = {a_r[WordW-2:0], 1'b0};
        b_nxt = {1'b0, b_r[WordW-1:1]};
      end
      OP_ABS_A: begin
        if (r_neg_r) begin
          a_nxt = alu_sum[WordW-1:0];
        end
      end
      OP_ABS_B: begin
        if (b_r[WordW-1]) begin
          b_nxt = alu_sum[WordW-1:0];
        end
      end
      OP_DIV_STEP: begin
        // Restoring step: keep the difference only when it did not borrow
        acc_nxt = alu_carry ? alu_sum[WordW-1:0] : shifted;
        a_nxt   = {a_r[WordW-2:0], alu_carry};
      end
      OP_NEG_Q: begin
        if (q_neg_r) begin
          a_nxt = alu_sum[WordW-1:0];
        end
      end
      OP_NEG_R: begin
        if (r_neg_r) begin
          acc_nxt = alu_sum[WordW-1:0];
        end
      end
      OP_CAPTURE: begin
        sts_out_nxt = status_r;
        if (err) begin
          res_out_nxt = '0;
          rem_out_nxt = '0;
        end else if (mode_r == MODE_DIV) begin
          res_out_nxt = word_t'(a_r);
          rem_out_nxt = word_t'(acc_r);
        end else begin
          res_out_nxt = word_t'(acc_r);
          rem_out_nxt = '0;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    q_neg_r   <= q_neg_nxt;
    r_neg_r   <= r_neg_nxt;
    status_r  <= status_nxt;
    res_out_r <= res_out_nxt;
    rem_out_r <= rem_out_nxt;
    sts_out_r <= sts_out_nxt;
  end

  assign out_result    = res_out_r;
  assign out_remainder = rem_out_r;
  assign out_status    = sts_out_r;

  `SIALU_ASSERT_NEXT(a_rem_below_divisor, clk, rst_n, op == OP_DIV_STEP, acc_r < b_r)
  `SIALU_ASSERT_NEXT(a_load_clears_acc, clk, rst_n, op == OP_LOAD, acc_r == '0)
  `SIALU_ASSERT_NEXT(a_err_zero_fields, clk, rst_n, op == OP_CAPTURE && err, out_result == '0 && out_remainder == '0)

endmodule

// ----- design/sialu_ctrl.sv -----
`timescale 1ns / 1ps
`include "signed_integer_alu_mul_div_assert.svh"

module sialu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sialu_pkg::mode_t  in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              div_err,
  output sialu_pkg::dp_op_t op
);
  import sialu_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   last;

  assign last = (cnt_r == cnt_t'(Steps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_IDLE;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          unique case (in_mode)
            MODE_ADD, MODE_SUB: state_nxt = S_ADDSUB;
            MODE_MUL:           state_nxt = S_MUL;
            MODE_DIV:           state_nxt = S_ABS_A;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADDSUB: begin
        op        = OP_ADDSUB;
        state_nxt = S_FINISH;
      end
      S_MUL: begin
        op      = OP_MUL_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_FINISH;
        end
      end
      S_ABS_A: begin
        if (div_err) begin
          state_nxt = S_FINISH;
        end else begin
          op        = OP_ABS_A;
          state_nxt = S_ABS_B;
        end
      end
      S_ABS_B: begin
        op        = OP_ABS_B;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        op      = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_NEG_Q;
        end
      end
      S_NEG_Q: begin
        op        = OP_NEG_Q;
        state_nxt = S_NEG_R;
      end
      S_NEG_R: begin
        op        = OP_NEG_R;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          op            = OP_CAPTURE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `SIALU_ASSERT_SAME(a_cnt_idle_zero, clk, rst_n, state_r != S_MUL && state_r != S_DIV, cnt_r == '0)
  `SIALU_ASSERT_NEXT(a_mul_runs_full, clk, rst_n, state_r == S_MUL && !last, state_r == S_MUL)
  `SIALU_ASSERT_NEXT(a_finish_holds, clk, rst_n, state_r == S_FINISH && out_valid_r && !out_ready, state_r == S_FINISH)

endmodule

// ----- design/signed_integer_alu_mul_div.sv -----
`timescale 1ns / 1ps
// Signed 32-bit arithmetic unit: add, subtract, multiply (low 32 bits of the
// product) and divide (quotient truncated toward zero, remainder with the sign
// of the dividend). One shared 33-bit adder/subtractor does all the work under
// a small sequencer, so the unit takes one transaction at a time. Add and
// subtract make a single adder pass; multiply runs 32 shift-add steps; divide
// takes the absolute value of each operand, runs 32 restoring shift-subtract
// steps, then fixes the signs of quotient and remainder. A zero divisor
// returns status 1 and the most negative value over minus one returns status
// 2, both with zero result fields. Add, subtract and multiply wrap silently.
// Results sit in an output register, so the input side reopens as soon as a
// result is captured, even if the consumer has not taken it.
module signed_integer_alu_mul_div (
  input logic         clk,
  input logic         rst_n,
  sialu_in_if.sink    in_ch,
  sialu_out_if.source out_ch
);
  import sialu_pkg::*;

  dp_op_t op;
  logic   div_err;

  // Sequencer: state, step counter and output valid flag
  sialu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .div_err   (div_err),
    .op        (op)
  );

  // Operand registers, shared adder and output payload register
  sialu_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .in_mode       (in_ch.mode),
    .in_a          (in_ch.operand_a),
    .in_b          (in_ch.operand_b),
    .div_err       (div_err),
    .out_result    (out_ch.result_value),
    .out_remainder (out_ch.remainder_value),
    .out_status    (out_ch.status)
  );

endmodule
